[design/pat_pkg.sv]
package pat_pkg;

  localparam int unsigned AddrW  = 48;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned OrdW   = 5;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 5;

  localparam logic [ModeW-1:0] MODE_ADD      = 2'd0;
  localparam logic [ModeW-1:0] MODE_READ     = 2'd1;
  localparam logic [ModeW-1:0] MODE_DEL_ORD  = 2'd2;
  localparam logic [ModeW-1:0] MODE_DEL_ADDR = 2'd3;

  localparam logic [StatW-1:0] STAT_DONE    = 2'd0;
  localparam logic [StatW-1:0] STAT_PRESENT = 2'd1;
  localparam logic [StatW-1:0] STAT_FAIL    = 2'd2;

endpackage

[design/paired_address_table.sv]
// Paired address table: one word in, one word out per operation.
// An operation runs a scan that reads the address memory one slot per cycle, then a
// drain state, and a finish state that commits the result when the output is free.
// Operations do not overlap: the input stalls until the result is committed, but a new
// word is taken while a finished result still waits in the output register.
// Reset: asynchronous, active low; the table comes up empty (used flags and count clear).
module paired_address_table #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pat_pkg::ModeW-1:0]     mode_i,
  input  logic [pat_pkg::AddrW-1:0]     key_address_i,
  input  logic [pat_pkg::OrdW-1:0]      ordinal_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pat_pkg::StatW-1:0]     status_o,
  output logic [pat_pkg::AddrW-1:0]     found_address_o,
  output logic [pat_pkg::CountW-1:0]    entry_count_o
);

  localparam int unsigned IW   = $clog2(ENTRIES);
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam int unsigned CmpW = (CW > pat_pkg::OrdW) ? CW + 1 : pat_pkg::OrdW + 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  logic [pat_pkg::ModeW-1:0] mode_q;
  logic [pat_pkg::AddrW-1:0] key_q;
  logic [pat_pkg::OrdW-1:0]  ord_q;

  logic [ENTRIES-1:0] used_q, used_d;
  logic [CW-1:0]      count_q, count_d;

  logic [pat_pkg::AddrW-1:0] mem [ENTRIES];
  logic [pat_pkg::AddrW-1:0] rdata_q;

  logic [IW-1:0] scan_idx_q, scan_idx_d;
  logic [IW-1:0] chk_idx_q;
  logic          chk_vld_q;

  logic [CW-1:0]             seen_q, seen_d;
  logic                      hit_q, hit_d;
  logic [IW-1:0]             hit_slot_q, hit_slot_d;
  logic [pat_pkg::AddrW-1:0] found_q, found_d;
  logic                      free_ok_q, free_ok_d;
  logic [IW-1:0]             free_slot_q, free_slot_d;

  logic                       out_valid_q, out_valid_d;
  logic [pat_pkg::StatW-1:0]  status_q, status_d;
  logic [pat_pkg::AddrW-1:0]  found_out_q, found_out_d;

  logic in_accept, out_free, commit, wr_en;
  logic chk_used, addr_match, ord_match, use_addr;
  logic [CmpW-1:0] seen_inc, count_ext;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign commit    = (state_q == ST_FINISH) && out_free;
  assign in_stall_o = (state_q != ST_IDLE);

  // check stage: one slot per cycle, on the data read from the scan address in the previous cycle
  assign chk_used   = used_q[chk_idx_q];
  assign addr_match = chk_used && (rdata_q == key_q);
  assign seen_inc   = CmpW'(seen_q) + CmpW'(1);
  assign ord_match  = chk_used && (seen_inc == CmpW'(ord_q));
  assign use_addr   = (mode_q == pat_pkg::MODE_ADD) || (mode_q == pat_pkg::MODE_DEL_ADDR);

  always_comb begin
    state_d     = state_q;
    scan_idx_d  = scan_idx_q;
    seen_d      = seen_q;
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    found_d     = found_q;
    free_ok_d   = free_ok_q;
    free_slot_d = free_slot_q;
    used_d      = used_q;
    count_d     = count_q;
    wr_en       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    found_out_d = found_out_q;

    if (chk_vld_q) begin
      if (chk_used) begin
        seen_d = seen_q + CW'(1);
      end
      if (!hit_q && (use_addr ? addr_match : ord_match)) begin
        hit_d      = 1'b1;
        hit_slot_d = chk_idx_q;
        found_d    = rdata_q;
      end
      if (!chk_used && !free_ok_q) begin
        free_ok_d   = 1'b1;
        free_slot_d = chk_idx_q;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d    = ST_SCAN;
          scan_idx_d = '0;
          seen_d     = '0;
          hit_d      = 1'b0;
          free_ok_d  = 1'b0;
        end
      end
      ST_SCAN: begin
        scan_idx_d = scan_idx_q + IW'(1);
        if (scan_idx_q == IW'(ENTRIES - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (commit) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          status_d    = pat_pkg::STAT_FAIL;
          found_out_d = '0;
          case (mode_q)
            pat_pkg::MODE_ADD: begin
              if (count_q >= CW'(ENTRIES)) begin
                status_d = pat_pkg::STAT_FAIL;
              end else if (hit_q) begin
                status_d = pat_pkg::STAT_PRESENT;
              end else begin
                wr_en               = 1'b1;
                used_d[free_slot_q] = 1'b1;
                count_d             = count_q + CW'(1);
                status_d            = pat_pkg::STAT_DONE;
              end
            end
            pat_pkg::MODE_READ: begin
              if (hit_q) begin
                status_d    = pat_pkg::STAT_DONE;
                found_out_d = found_q;
              end
            end
            default: begin
              // both delete modes: drop the matched slot
              if (hit_q) begin
                used_d[hit_slot_q] = 1'b0;
                count_d            = count_q - CW'(1);
                status_d           = pat_pkg::STAT_DONE;
              end
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      count_q     <= '0;
      scan_idx_q  <= '0;
      chk_idx_q   <= '0;
      chk_vld_q   <= 1'b0;
      seen_q      <= '0;
      hit_q       <= 1'b0;
      hit_slot_q  <= '0;
      free_ok_q   <= 1'b0;
      free_slot_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      count_q     <= count_d;
      scan_idx_q  <= scan_idx_d;
      chk_idx_q   <= scan_idx_q;
      chk_vld_q   <= (state_q == ST_SCAN);
      seen_q      <= seen_d;
      hit_q       <= hit_d;
      hit_slot_q  <= hit_slot_d;
      free_ok_q   <= free_ok_d;
      free_slot_q <= free_slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= mode_i;
      key_q  <= key_address_i;
      ord_q  <= ordinal_i;
    end
    found_q     <= found_d;
    status_q    <= status_d;
    found_out_q <= found_out_d;
  end

  // address memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[free_slot_q] <= key_q;
    end
    rdata_q <= mem[scan_idx_q];
  end

  assign count_ext       = CmpW'(count_q);
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign found_address_o = found_out_q;
  assign entry_count_o   = count_ext[pat_pkg::CountW-1:0];

endmodule

[design/pat_checker.sv]
module pat_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [pat_pkg::StatW-1:0]     status_o,
  input logic [pat_pkg::AddrW-1:0]     found_address_o,
  input logic [pat_pkg::CountW-1:0]    entry_count_o
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(found_address_o) && $stable(entry_count_o))
    else $error("stalled result word changed");

  // one operation at a time: input stalls right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= pat_pkg::STAT_FAIL)
    else $error("undefined status code");

  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != pat_pkg::STAT_DONE |-> found_address_o == '0)
    else $error("found address set on a failed operation");

endmodule

bind paired_address_table pat_checker u_pat_checker (.*);

[tb/sv/testbench.sv]
module testbench;

  localparam int SLOTS = 16;
  localparam int POOL_SIZE = 24;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [pat_pkg::ModeW-1:0] ALL_MODES [4] = '{
    pat_pkg::MODE_ADD, pat_pkg::MODE_READ, pat_pkg::MODE_DEL_ORD, pat_pkg::MODE_DEL_ADDR};

  typedef struct packed {
    logic [pat_pkg::StatW-1:0]  status;
    logic [pat_pkg::AddrW-1:0]  found;
    logic [pat_pkg::CountW-1:0] count;
  } table_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [pat_pkg::ModeW-1:0]  mode_i = pat_pkg::MODE_ADD;
  logic [pat_pkg::AddrW-1:0]  key_address_i = '0;
  logic [pat_pkg::OrdW-1:0]   ordinal_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [pat_pkg::StatW-1:0]  status_o;
  logic [pat_pkg::AddrW-1:0]  found_address_o;
  logic [pat_pkg::CountW-1:0] entry_count_o;

  // Shadow copy of the table
  bit                        tbl_used [SLOTS] = '{default: 1'b0};
  logic [pat_pkg::AddrW-1:0] tbl_addr [SLOTS];
  int                        tbl_count = 0;

  table_result_t             awaited_results [$];
  table_result_t             head_result;
  logic [pat_pkg::AddrW-1:0] addr_pool [POOL_SIZE];
  int                        mismatches = 0;
  int                        cycle_count = 0;
  int                        sender_idle_pct = 0;
  int                        receiver_stall_pct = 0;
  int                        hold_left = 0;
  bit                        hold_req = 1'b0;
  bit                        hold_ack = 1'b0;

  paired_address_table #(
    .ENTRIES(SLOTS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .key_address_i  (key_address_i),
    .ordinal_i      (ordinal_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .found_address_o(found_address_o),
    .entry_count_o  (entry_count_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("** paired_address_table: FAILED **");
      $finish;
    end
  end

  // Long hold-off counts down on its own; the stall driver only looks at it
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < receiver_stall_pct);
  end

  function automatic logic [pat_pkg::AddrW-1:0] rand_addr();
    bit [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[pat_pkg::AddrW-1:0];
  endfunction

  function automatic int find_key(logic [pat_pkg::AddrW-1:0] key);
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_used[i] && tbl_addr[i] == key) return i;
    end
    return SLOTS;
  endfunction

  function automatic int find_ordinal(logic [pat_pkg::OrdW-1:0] ord);
    int seen;
    seen = 0;
    if (ord == 0 || ord > SLOTS) return SLOTS;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_used[i]) begin
        seen++;
        if (seen == ord) return i;
      end
    end
    return SLOTS;
  endfunction

  function automatic table_result_t apply_table_op(logic [pat_pkg::ModeW-1:0] op,
                                                   logic [pat_pkg::AddrW-1:0] key,
                                                   logic [pat_pkg::OrdW-1:0] ord);
    table_result_t res;
    int slot;
    res.status = pat_pkg::STAT_FAIL;
    res.found  = '0;
    case (op)
      pat_pkg::MODE_ADD: begin
        if (tbl_count < SLOTS) begin
          if (find_key(key) < SLOTS) begin
            res.status = pat_pkg::STAT_PRESENT;
          end else begin
            slot = 0;
            while (tbl_used[slot]) slot++;
            tbl_used[slot] = 1'b1;
            tbl_addr[slot] = key;
            tbl_count++;
            res.status = pat_pkg::STAT_DONE;
          end
        end
      end
      pat_pkg::MODE_READ: begin
        slot = find_ordinal(ord);
        if (slot < SLOTS) begin
          res.found  = tbl_addr[slot];
          res.status = pat_pkg::STAT_DONE;
        end
      end
      pat_pkg::MODE_DEL_ORD: begin
        slot = find_ordinal(ord);
        if (slot < SLOTS) begin
          tbl_used[slot] = 1'b0;
          tbl_count--;
          res.status = pat_pkg::STAT_DONE;
        end
      end
      default: begin
        slot = find_key(key);
        if (slot < SLOTS) begin
          tbl_used[slot] = 1'b0;
          tbl_count--;
          res.status = pat_pkg::STAT_DONE;
        end
      end
    endcase
    res.count = tbl_count[pat_pkg::CountW-1:0];
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // Leave valid high on return so the next word can follow without a gap
  task automatic send_word(input logic [pat_pkg::ModeW-1:0] op,
                           input logic [pat_pkg::AddrW-1:0] key,
                           input logic [pat_pkg::OrdW-1:0] ord);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= op;
    key_address_i <= key;
    ordinal_i     <= ord;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    awaited_results.push_back(apply_table_op(op, key, ord));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected word status %0d found %h count %0d",
                                status_o, found_address_o, entry_count_o));
      end else begin
        head_result = awaited_results.pop_front();
        if (status_o !== head_result.status || found_address_o !== head_result.found ||
            entry_count_o !== head_result.count) begin
          flag_mismatch($sformatf(
            "exp status %0d found %h count %0d, got status %0d found %h count %0d",
            head_result.status, head_result.found, head_result.count,
            status_o, found_address_o, entry_count_o));
        end
      end
    end
  end

  task automatic test_empty_table();
    send_word(pat_pkg::MODE_READ, '0, pat_pkg::OrdW'(1));
    send_word(pat_pkg::MODE_DEL_ORD, '1, '0);
    send_word(pat_pkg::MODE_DEL_ADDR, '0, '1);
  endtask

  task automatic test_add_and_lookup();
    send_word(pat_pkg::MODE_ADD, '0, '0);
    send_word(pat_pkg::MODE_ADD, '1, '0);
    send_word(pat_pkg::MODE_ADD, '1, '0);
    send_word(pat_pkg::MODE_READ, '0, pat_pkg::OrdW'(2));
    send_word(pat_pkg::MODE_READ, '0, pat_pkg::OrdW'(3));
    send_word(pat_pkg::MODE_DEL_ADDR, '1, '0);
  endtask

  task automatic test_full_table();
    logic [pat_pkg::AddrW-1:0] pattern;
    for (int i = 0; tbl_count < SLOTS; i++) begin
      pattern = pat_pkg::AddrW'(1) << (3 * i);
      send_word(pat_pkg::MODE_ADD, (i % 2 != 0) ? ~pattern : pattern, '0);
    end
    // Full check wins over the duplicate check
    send_word(pat_pkg::MODE_ADD, '0, '0);
    send_word(pat_pkg::MODE_READ, '0, pat_pkg::OrdW'(SLOTS));
    send_word(pat_pkg::MODE_DEL_ORD, '0, pat_pkg::OrdW'(1));
    send_word(pat_pkg::MODE_ADD, '1, '0);
    send_word(pat_pkg::MODE_READ, '0, pat_pkg::OrdW'(1));
  endtask

  task automatic test_output_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_req = ~hold_req;
    for (int i = 0; i < 12; i++) begin
      send_word(ALL_MODES[$urandom_range(3)], addr_pool[$urandom_range(POOL_SIZE - 1)],
                pat_pkg::OrdW'($urandom_range(SLOTS)));
    end
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_words);
    logic [pat_pkg::ModeW-1:0] op;
    logic [pat_pkg::AddrW-1:0] key;
    logic [pat_pkg::OrdW-1:0]  ord;
    int                        add_bias;
    int                        roll;
    int                        live [$];
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int n = 0; n < n_words; n++) begin
      key = addr_pool[$urandom_range(POOL_SIZE - 1)];
      ord = pat_pkg::OrdW'($urandom_range(SLOTS));
      if ($urandom_range(99) < 8) begin
        op  = ALL_MODES[$urandom_range(3)];
        key = rand_addr();
      end else begin
        // Keep the fill level moving between empty and full
        add_bias = (tbl_count < 4) ? 60 : (tbl_count > 12) ? 20 : 40;
        op = ($urandom_range(99) < add_bias) ? pat_pkg::MODE_ADD
                                             : ALL_MODES[$urandom_range(1, 3)];
        if (op == pat_pkg::MODE_ADD && $urandom_range(99) < 30) key = rand_addr();
        if (op == pat_pkg::MODE_DEL_ADDR) begin
          live.delete();
          for (int i = 0; i < SLOTS; i++) begin
            if (tbl_used[i]) live.push_back(i);
          end
          if (live.size() != 0 && $urandom_range(99) < 70) begin
            key = tbl_addr[live[$urandom_range(live.size() - 1)]];
          end
        end
        if (op == pat_pkg::MODE_READ || op == pat_pkg::MODE_DEL_ORD) begin
          roll = $urandom_range(99);
          if (roll < 80 && tbl_count > 0) begin
            ord = pat_pkg::OrdW'($urandom_range(1, tbl_count));
          end else if (roll < 90) begin
            ord = '0;
          end
        end
      end
      send_word(op, key, ord);
    end
  endtask

  initial begin
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = rand_addr();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_add_and_lookup();
    test_full_table();
    test_output_backpressure();
    test_random_traffic(0, 0, 128);
    test_random_traffic(80, 0, 128);
    test_random_traffic(0, 80, 128);
    test_random_traffic(10, 10, 128);

    in_valid_i <= 1'b0;
    receiver_stall_pct = 0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("** paired_address_table: PASSED **");
    end else begin
      $display("** paired_address_table: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
design/pat_pkg.sv
design/paired_address_table.sv
design/pat_checker.sv
tb/sv/testbench.sv
